>>> hw/rtl/register_window_planner_macros.svh
// assertion macros shared by the register window planner rtl
// included by files that check their own logic; no other dependencies
`ifndef REGISTER_WINDOW_PLANNER_MACROS_SVH
`define REGISTER_WINDOW_PLANNER_MACROS_SVH
`ifndef SYNTH
`define RWP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rwp assertion failed");
`define RWP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rwp assertion failed");
`else
`define RWP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RWP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/rwp_pkg.sv
// types, codes and constants of the register window planner
// used by every rtl module of the block; depends on nothing
`default_nettype none
package rwp_pkg;

  localparam int NUM_REGS_DEF    = 256;
  localparam int NUM_CLASSES_DEF = 4;
  localparam int WORD_W          = 64;

  // commands
  localparam logic [1:0] CMD_WR_FORBID = 2'd0;
  localparam logic [1:0] CMD_WR_LIVE   = 2'd1;
  localparam logic [1:0] CMD_PLAN      = 2'd2;

  // plan status
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INVALID    = 3'd1;
  localparam logic [2:0] ST_MISALIGNED = 3'd2;
  localparam logic [2:0] ST_RANGE      = 3'd3;
  localparam logic [2:0] ST_FORBIDDEN  = 3'd4;
  localparam logic [2:0] ST_LIVE       = 3'd5;
  localparam logic [2:0] ST_NO_WINDOW  = 3'd6;

  // plan source
  localparam logic [2:0] SRC_NONE     = 3'd0;
  localparam logic [2:0] SRC_EXPLICIT = 3'd1;
  localparam logic [2:0] SRC_DEAD     = 3'd2;
  localparam logic [2:0] SRC_GROWTH   = 3'd3;
  localparam logic [2:0] SRC_SPILL    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_ARCH_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_SPILL        = 2'd1;
  localparam logic [1:0] CFG_SPILL_GROWTH = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  rclass;
    logic [1:0]  word_index;
    logic [63:0] word_data;
    logic [8:0]  window_count;
    logic [6:0]  alignment;
    logic [8:0]  scan_from;
    logic        given_base_valid;
    logic [8:0]  given_base;
    logic [8:0]  current_allocation;
    logic [8:0]  max_referenced;
    logic        spill_only;
  } rwp_in_t;

  typedef struct packed {
    logic [2:0] plan_status;
    logic [2:0] plan_source;
    logic       window_base_valid;
    logic [7:0] window_base;
    logic [8:0] window_size;
    logic [8:0] descriptor_count;
  } rwp_out_t;

  typedef struct packed {
    logic [8:0] reg_limit;
    logic       spill_allowed;
    logic       spill_growth_allowed;
  } rwp_cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/register_window_planner.sv
// Register window planner: aligned first-fit window search over per-class
// forbidden and live bitmaps held in two synchronous stores.
//
// Input channel (in_valid / in_stall / in_item): bitmap word writes and plan
// requests. A word write is accepted when idle and gives no result. A plan
// loads the class bitmap (one word a cycle), then walks candidate
// bases: aligning a base is a repeated add of the alignment, one add a
// cycle, and each window is checked one register a cycle, for up to
// four passes. A rejected request still passes through S_LOAD and
// S_DECIDE to S_DONE before its result is registered, and the next
// item is taken once the planner is back in S_IDLE with in_stall low.
// One item is worked on at a time; in_stall is high while a plan runs.
// Output channel (out_valid / out_stall / out_item): one result per plan,
// held in an output register; a new item is taken while it waits, and a
// finished plan waits for the register to free when out_stall stays high.
// Configuration (cfg_we / cfg_index / cfg_data) must be written only while
// idle (unchecked). Reset clears both bitmaps through per-entry valid bits,
// with no clearing pass, and sets the limit to 256 with spilling disabled.
`default_nettype none
module register_window_planner #(
  parameter int NUM_REGS    = rwp_pkg::NUM_REGS_DEF,
  parameter int NUM_CLASSES = rwp_pkg::NUM_CLASSES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rwp_pkg::rwp_in_t  in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rwp_pkg::rwp_out_t      out_item,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [8:0]        cfg_data
);

  localparam int WORDS = (NUM_REGS + 63) / 64;
  localparam int DEPTH = NUM_CLASSES * WORDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rwp_pkg::rwp_cfg_t          cfg;
  logic                       accept;
  logic                       wr_ok;
  logic                       wr_forbid;
  logic                       wr_live;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic [rwp_pkg::WORD_W-1:0] forbid_word;
  logic [rwp_pkg::WORD_W-1:0] live_word;
  logic                       busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reg_limit            <= 9'd256;
      cfg.spill_allowed        <= 1'b0;
      cfg.spill_growth_allowed <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rwp_pkg::CFG_ARCH_LIMIT:   cfg.reg_limit            <= cfg_data;
        rwp_pkg::CFG_SPILL:        cfg.spill_allowed        <= cfg_data[0];
        rwp_pkg::CFG_SPILL_GROWTH: cfg.spill_growth_allowed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input handshake and word write decode
  always_comb begin
    in_stall  = busy;
    accept    = in_valid && !busy;
    wr_ok     = (32'(in_item.rclass) < 32'(NUM_CLASSES)) &&
                (32'(in_item.word_index) < 32'(WORDS));
    wr_forbid = accept && wr_ok && (in_item.command == rwp_pkg::CMD_WR_FORBID);
    wr_live   = accept && wr_ok && (in_item.command == rwp_pkg::CMD_WR_LIVE);
    wr_addr   = AW'(int'(in_item.rclass) * WORDS + int'(in_item.word_index));
  end

  rwp_map_mem #(.DEPTH(DEPTH), .AW(AW)) u_forbid_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_forbid),
    .wr_addr (wr_addr),
    .wr_data (in_item.word_data),
    .rd_addr (rd_addr),
    .rd_data (forbid_word)
  );

  rwp_map_mem #(.DEPTH(DEPTH), .AW(AW)) u_live_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_live),
    .wr_addr (wr_addr),
    .wr_data (in_item.word_data),
    .rd_addr (rd_addr),
    .rd_data (live_word)
  );

  rwp_planner #(
    .NUM_REGS    (NUM_REGS),
    .NUM_CLASSES (NUM_CLASSES),
    .WORDS       (WORDS),
    .AW          (AW)
  ) u_planner (
    .clk         (clk),
    .rst         (rst),
    .start       (accept && (in_item.command == rwp_pkg::CMD_PLAN)),
    .req_in      (in_item),
    .busy        (busy),
    .cfg         (cfg),
    .rd_addr     (rd_addr),
    .forbid_word (forbid_word),
    .live_word   (live_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule
`default_nettype wire

>>> hw/rtl/rwp_map_mem.sv
// one bitmap store: synchronous memory with per-entry valid bits
// entries never written read as zero; uses rwp_pkg for the word width
`default_nettype none
module rwp_map_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [rwp_pkg::WORD_W-1:0] wr_data,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [rwp_pkg::WORD_W-1:0] rd_data
);

  logic [rwp_pkg::WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld;

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule
`default_nettype wire

>>> hw/rtl/rwp_planner.sv
// plan sequencer: loads a class bitmap from the stores, then runs the
// aligned window passes one register a cycle; uses rwp_pkg and the macros
`default_nettype none
`include "register_window_planner_macros.svh"
module rwp_planner #(
  parameter int NUM_REGS    = rwp_pkg::NUM_REGS_DEF,
  parameter int NUM_CLASSES = rwp_pkg::NUM_CLASSES_DEF,
  parameter int WORDS       = (NUM_REGS + 63) / 64,
  parameter int AW          = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire rwp_pkg::rwp_in_t           req_in,
  output logic                            busy,
  input  wire rwp_pkg::rwp_cfg_t          cfg,
  output logic      [AW-1:0]              rd_addr,
  input  wire logic [rwp_pkg::WORD_W-1:0] forbid_word,
  input  wire logic [rwp_pkg::WORD_W-1:0] live_word,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output rwp_pkg::rwp_out_t               out_item
);

  localparam int CW  = $clog2(NUM_REGS + 1) + 3;
  localparam int RW  = $clog2(NUM_REGS);
  localparam int MW  = WORDS * rwp_pkg::WORD_W;
  localparam int WCW = $clog2(WORDS + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_ADV    = 6'b001000,
    S_SCAN   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  typedef enum logic [4:0] {
    P_EXPL     = 5'b00001,
    P_DEAD_CUR = 5'b00010,
    P_FRESH    = 5'b00100,
    P_DEAD_LIM = 5'b01000,
    P_SPILL    = 5'b10000
  } pass_t;

  state_t            state;
  pass_t             pass;
  rwp_pkg::rwp_in_t  req;
  rwp_pkg::rwp_out_t res;
  logic [WCW-1:0]    ld_cnt;
  logic [MW-1:0]     fbits;
  logic [MW-1:0]     lbits;
  logic [CW-1:0]     b;
  logic [CW-1:0]     target;
  logic [CW-1:0]     plim;
  logic [CW-1:0]     r;
  logic [8:0]        off;
  logic              fhit;
  logic              lhit;

  logic [CW-1:0] lim;
  logic [CW-1:0] count_c;
  logic [CW-1:0] cur_c;
  logic [CW-1:0] maxref_c;
  logic [CW-1:0] start_c;
  logic [CW-1:0] xbase_c;
  logic [CW-1:0] al_c;
  logic [CW-1:0] end_c;
  logic [CW-1:0] grow_from;
  logic [8:0]    desc_max;
  logic          f_bit;
  logic          l_bit;
  logic          need_dead;
  logic          invalid;
  logic          res_free;

  // widened request fields and derived values
  always_comb begin
    lim      = (CW'(cfg.reg_limit) > CW'(NUM_REGS)) ? CW'(NUM_REGS)
                                                     : CW'(cfg.reg_limit);
    count_c  = CW'(req.window_count);
    cur_c    = CW'(req.current_allocation);
    maxref_c = CW'(req.max_referenced);
    start_c  = CW'(req.scan_from);
    xbase_c  = CW'(req.given_base);
    al_c     = CW'(req.alignment);
    end_c    = b + count_c;
    desc_max = (end_c > cur_c) ? end_c[8:0] : req.current_allocation;
    grow_from = start_c;
    if (cur_c > grow_from) begin
      grow_from = cur_c;
    end
    if (maxref_c > grow_from) begin
      grow_from = maxref_c;
    end
    f_bit     = (r < CW'(NUM_REGS)) ? fbits[r[RW-1:0]] : 1'b0;
    l_bit     = (r < CW'(NUM_REGS)) ? lbits[r[RW-1:0]] : 1'b0;
    need_dead = (pass == P_DEAD_CUR) || (pass == P_DEAD_LIM);
    invalid   = (32'(req.rclass) >= 32'(NUM_CLASSES)) || (req.window_count == '0) ||
                (req.alignment == '0) || (lim == '0) || (cur_c > lim) || (maxref_c > lim);
    rd_addr   = AW'(int'(req.rclass) * WORDS + int'(ld_cnt));
    res_free  = !out_valid || !out_stall;
  end

  assign busy = (state != S_IDLE);

  // bitmap capture from the registered store read, one word behind the read address
  always_ff @(posedge clk) begin
    if (state == S_LOAD && ld_cnt != '0) begin
      fbits[rwp_pkg::WORD_W * int'(ld_cnt - 1'b1) +: rwp_pkg::WORD_W] <= forbid_word;
      lbits[rwp_pkg::WORD_W * int'(ld_cnt - 1'b1) +: rwp_pkg::WORD_W] <= live_word;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass      <= P_DEAD_CUR;
      out_valid <= 1'b0;
      ld_cnt    <= '0;
    end else begin
      // result taken and nothing new to deliver
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req    <= req_in;
            ld_cnt <= '0;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (ld_cnt == WCW'(WORDS)) begin
            state <= S_DECIDE;
          end
          ld_cnt <= ld_cnt + 1'b1;
        end
        S_DECIDE: begin
          res.window_size       <= req.window_count;
          res.plan_source       <= rwp_pkg::SRC_NONE;
          res.window_base_valid <= 1'b0;
          res.window_base       <= '0;
          res.descriptor_count  <= req.current_allocation;
          res.plan_status       <= invalid ? rwp_pkg::ST_INVALID : rwp_pkg::ST_NO_WINDOW;
          b <= '0;
          priority if (invalid) begin
            state <= S_DONE;
          end else if (req.given_base_valid) begin
            pass   <= P_EXPL;
            target <= xbase_c;
            plim   <= lim;
            state  <= S_ADV;
          end else if (req.spill_only) begin
            if (cfg.spill_allowed) begin
              pass   <= P_SPILL;
              target <= start_c;
              plim   <= cfg.spill_growth_allowed ? lim : cur_c;
              state  <= S_ADV;
            end else begin
              state <= S_DONE;
            end
          end else begin
            pass   <= P_DEAD_CUR;
            target <= start_c;
            plim   <= cur_c;
            state  <= S_ADV;
          end
        end
        S_ADV: begin
          if (b >= target) begin
            if (pass == P_EXPL) begin
              priority if (b != xbase_c) begin
                res.plan_status <= rwp_pkg::ST_MISALIGNED;
                state           <= S_DONE;
              end else if (end_c > plim) begin
                res.plan_status <= rwp_pkg::ST_RANGE;
                state           <= S_DONE;
              end else begin
                r     <= b;
                off   <= '0;
                fhit  <= 1'b0;
                lhit  <= 1'b0;
                state <= S_SCAN;
              end
            end else if (end_c > plim) begin
              // pass failed: move to the next pass, or finish if there is none
              b <= '0;
              unique case (pass)
                P_DEAD_CUR: begin
                  pass   <= P_FRESH;
                  target <= grow_from;
                  plim   <= lim;
                end
                P_FRESH: begin
                  pass   <= P_DEAD_LIM;
                  target <= start_c;
                  plim   <= lim;
                end
                P_DEAD_LIM: begin
                  if (cfg.spill_allowed) begin
                    pass   <= P_SPILL;
                    target <= start_c;
                    plim   <= cur_c;
                  end else begin
                    state <= S_DONE;
                  end
                end
                default: begin
                  state <= S_DONE;
                end
              endcase
            end else begin
              r     <= b;
              off   <= '0;
              state <= S_SCAN;
            end
          end else begin
            b <= b + al_c;
          end
        end
        S_SCAN: begin
          if (off == req.window_count) begin
            // whole window checked
            state <= S_DONE;
            if (pass == P_EXPL && fhit) begin
              res.plan_status <= rwp_pkg::ST_FORBIDDEN;
            end else if (pass == P_EXPL && lhit && xbase_c < maxref_c) begin
              res.plan_status <= rwp_pkg::ST_LIVE;
            end else begin
              res.plan_status       <= rwp_pkg::ST_OK;
              res.window_base_valid <= 1'b1;
              res.window_base       <= b[7:0];
              unique case (pass)
                P_EXPL: begin
                  res.plan_source      <= rwp_pkg::SRC_EXPLICIT;
                  res.descriptor_count <= desc_max;
                end
                P_DEAD_CUR: begin
                  res.plan_source      <= rwp_pkg::SRC_DEAD;
                  res.descriptor_count <= req.current_allocation;
                end
                P_FRESH: begin
                  res.plan_source      <= rwp_pkg::SRC_GROWTH;
                  res.descriptor_count <= end_c[8:0];
                end
                P_DEAD_LIM: begin
                  res.plan_source      <= rwp_pkg::SRC_GROWTH;
                  res.descriptor_count <= desc_max;
                end
                default: begin
                  res.plan_source      <= rwp_pkg::SRC_SPILL;
                  res.descriptor_count <= desc_max;
                end
              endcase
            end
          end else if (pass == P_EXPL) begin
            fhit <= fhit | f_bit;
            lhit <= lhit | l_bit;
            r    <= r + 1'b1;
            off  <= off + 1'b1;
          end else if (f_bit || (need_dead && l_bit)) begin
            // blocked register: next candidate lies above it
            target <= r + 1'b1;
            state  <= S_ADV;
          end else begin
            r   <= r + 1'b1;
            off <= off + 1'b1;
          end
        end
        S_DONE: begin
          if (res_free) begin
            out_valid <= 1'b1;
            out_item  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `RWP_ASSERT_IMP(a_off_in_window, clk, rst, state == S_SCAN, off <= req.window_count)
  `RWP_ASSERT_IMP(a_scan_fits, clk, rst, state == S_SCAN, end_c <= plim)
  `RWP_ASSERT_IMP(a_base_means_ok, clk, rst, out_valid && out_item.window_base_valid, out_item.plan_status == rwp_pkg::ST_OK)
  `RWP_ASSERT_NXT(a_done_delivers, clk, rst, state == S_DONE && res_free, out_valid && state == S_IDLE)

endmodule
`default_nettype wire
